@@ hw/rtl/sgseb_pkg.sv @@
// Shared constants and the edge-pattern function for the signed graph spin energy bound unit.
`timescale 1ns / 1ps
package sgseb_pkg;

	// Field widths fixed by the interface.
	localparam int MASK_W   = 28;
	localparam int ENERGY_W = 6;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	// The edge mask is counted in four independent chunks of seven bits.
	localparam int CHUNK_W = 7;
	localparam int CHUNKS  = 4;
	localparam int PART_W  = 3;

	// Register map: word index taken from paddr above the byte offset.
	localparam logic [ADDR_W-3:0] REG_THRESHOLD = 1'b0;
	localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 6'd12;

	// For spin code 'code', bit k of the result is set when the two spins of
	// edge k differ, so that edge contributes -1 before its sign is applied.
	function automatic logic [MASK_W-1:0] edge_pattern(input int free_verts, input int code);
		logic [MASK_W-1:0] pat;
		int bit_idx;
		pat = '0;
		bit_idx = 0;
		for (int i = 1; i <= free_verts; i++) begin
			for (int j = i + 1; j <= free_verts; j++) begin
				pat[bit_idx] = ((code >> (i - 1)) & 1) != ((code >> (j - 1)) & 1);
				bit_idx++;
			end
		end
		return pat;
	endfunction

endpackage

@@ hw/rtl/sgseb_lane.sv @@
// One spin-vector lane: counts the negative terms of the energy for a fixed spin code.
`timescale 1ns / 1ps
module sgseb_lane import sgseb_pkg::*; #(
	parameter int FREE_VERTS = 8,
	parameter int CODE       = 0
) (
	input  logic                clk,
	input  logic [MASK_W-1:0]   mask_s1,
	output logic [ENERGY_W-1:0] neg_count_s2
);

	localparam int EDGES = (FREE_VERTS * (FREE_VERTS - 1)) / 2;
	localparam logic [MASK_W-1:0] PATTERN = edge_pattern(FREE_VERTS, CODE);
	localparam logic [MASK_W-1:0] EDGE_MASK = {MASK_W{1'b1}} >> (MASK_W - EDGES);
	localparam logic [ENERGY_W-1:0] LIN_NEG = ENERGY_W'($countones(CODE));

	logic [MASK_W-1:0]   diff;
	logic [PART_W-1:0]   part [CHUNKS];
	logic [ENERGY_W-1:0] neg_count;

	// An edge term is negative when its sign bit differs from the spin product.
	always_comb begin
		diff = (mask_s1 ^ PATTERN) & EDGE_MASK;
		for (int ch = 0; ch < CHUNKS; ch++) begin
			part[ch] = '0;
			for (int b = 0; b < CHUNK_W; b++) begin
				part[ch] = part[ch] + PART_W'(diff[ch*CHUNK_W + b]);
			end
		end
		neg_count = LIN_NEG;
		for (int ch = 0; ch < CHUNKS; ch++) begin
			neg_count = neg_count + ENERGY_W'(part[ch]);
		end
	end

	always_ff @(posedge clk) begin
		neg_count_s2 <= neg_count;
	end

endmodule

@@ hw/rtl/sgseb_minmax.sv @@
// Two-stage registered min/max tree over the per-lane negative-term counts.
`timescale 1ns / 1ps
module sgseb_minmax import sgseb_pkg::*; #(
	parameter int FREE_VERTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  logic [ENERGY_W-1:0] count_s2 [1 << FREE_VERTS],
	output logic                valid_s4,
	output logic [ENERGY_W-1:0] kmin_s4,
	output logic [ENERGY_W-1:0] kmax_s4
);

	localparam int HALF   = FREE_VERTS / 2;
	localparam int GSZ    = 1 << HALF;
	localparam int REST   = FREE_VERTS - HALF;
	localparam int GROUPS = 1 << REST;

	logic                valid_s3;
	logic [ENERGY_W-1:0] gmin [GROUPS];
	logic [ENERGY_W-1:0] gmax [GROUPS];
	logic [ENERGY_W-1:0] gmin_s3 [GROUPS];
	logic [ENERGY_W-1:0] gmax_s3 [GROUPS];
	logic [ENERGY_W-1:0] kmin;
	logic [ENERGY_W-1:0] kmax;

	// First stage: reduce each group of lanes by a pairwise tree.
	always_comb begin
		logic [ENERGY_W-1:0] lo [GSZ];
		logic [ENERGY_W-1:0] hi [GSZ];
		for (int g = 0; g < GROUPS; g++) begin
			for (int e = 0; e < GSZ; e++) begin
				lo[e] = count_s2[g*GSZ + e];
				hi[e] = count_s2[g*GSZ + e];
			end
			for (int lvl = 0; lvl < HALF; lvl++) begin
				for (int p = 0; p < (GSZ >> (lvl + 1)); p++) begin
					lo[p] = (lo[2*p] < lo[2*p+1]) ? lo[2*p] : lo[2*p+1];
					hi[p] = (hi[2*p] > hi[2*p+1]) ? hi[2*p] : hi[2*p+1];
				end
			end
			gmin[g] = lo[0];
			gmax[g] = hi[0];
		end
	end

	// Second stage: reduce the group results to one minimum and one maximum.
	always_comb begin
		logic [ENERGY_W-1:0] lo [GROUPS];
		logic [ENERGY_W-1:0] hi [GROUPS];
		for (int g = 0; g < GROUPS; g++) begin
			lo[g] = gmin_s3[g];
			hi[g] = gmax_s3[g];
		end
		for (int lvl = 0; lvl < REST; lvl++) begin
			for (int p = 0; p < (GROUPS >> (lvl + 1)); p++) begin
				lo[p] = (lo[2*p] < lo[2*p+1]) ? lo[2*p] : lo[2*p+1];
				hi[p] = (hi[2*p] > hi[2*p+1]) ? hi[2*p] : hi[2*p+1];
			end
		end
		kmin = lo[0];
		kmax = hi[0];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		gmin_s3 <= gmin;
		gmax_s3 <= gmax;
		kmin_s4 <= kmin;
		kmax_s4 <= kmax;
	end

	// Valid bits follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

endmodule

@@ hw/rtl/signed_graph_spin_energy_bound_unit.sv @@
// Top level of the signed graph spin energy bound unit: input stage, lanes, tree, result stage, APB.
`timescale 1ns / 1ps
// The unit takes one 28-bit edge signing per clock cycle and never raises busy, so a new
// mask may be started in every cycle. All 2^(VERTICES-1) spin vectors are evaluated in
// parallel lanes, one per vector, followed by a registered min/max tree; the result strobe
// done is high for one cycle once the mask has passed the input, lane, tree and result
// registers, in the order the masks were started. The receiver cannot stall, so every result
// must be taken when done is high. The threshold register at byte address 0 should only be
// written while no mask is in flight.
module signed_graph_spin_energy_bound_unit import sgseb_pkg::*; #(
	parameter int VERTICES = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MASK_W-1:0]   signing_mask,
	output logic                done,
	output logic                passes,
	output logic [ENERGY_W-1:0] peak_energy,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam int FREE_VERTS = VERTICES - 1;
	localparam int SPINS      = 1 << FREE_VERTS;
	localparam int EDGES      = (FREE_VERTS * (FREE_VERTS - 1)) / 2;
	localparam int DIST_W     = ENERGY_W + 2;
	localparam logic signed [DIST_W-1:0] TOTAL = DIST_W'(FREE_VERTS + EDGES);

	logic                accept;
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s4;
	logic [MASK_W-1:0]   mask_s1;
	logic [ENERGY_W-1:0] count_s2 [SPINS];
	logic [ENERGY_W-1:0] kmin_s4;
	logic [ENERGY_W-1:0] kmax_s4;
	logic [ENERGY_W-1:0] threshold_q;
	logic                done_s5;
	logic                passes_s5;
	logic [ENERGY_W-1:0] peak_s5;
	logic signed [DIST_W-1:0] lo_dist;
	logic signed [DIST_W-1:0] hi_dist;
	logic [ENERGY_W-1:0] lo_abs;
	logic [ENERGY_W-1:0] hi_abs;
	logic [ENERGY_W-1:0] peak;
	logic                cfg_write;

	// The pipeline never stalls, so a new beat is taken whenever start is high.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Input stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_s1 <= signing_mask;
		end
	end

	// One lane per spin vector.
	for (genvar c = 0; c < SPINS; c++) begin : g_lane
		sgseb_lane #(
			.FREE_VERTS(FREE_VERTS),
			.CODE      (c)
		) u_lane (
			.clk         (clk),
			.mask_s1     (mask_s1),
			.neg_count_s2(count_s2[c])
		);
	end

	sgseb_minmax #(
		.FREE_VERTS(FREE_VERTS)
	) u_minmax (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s2(valid_s2),
		.count_s2(count_s2),
		.valid_s4(valid_s4),
		.kmin_s4 (kmin_s4),
		.kmax_s4 (kmax_s4)
	);

	// The energy is TOTAL - 2k for k negative terms, so the peak magnitude comes from
	// the smallest or the largest k.
	always_comb begin
		lo_dist = TOTAL - $signed({1'b0, kmin_s4, 1'b0});
		hi_dist = TOTAL - $signed({1'b0, kmax_s4, 1'b0});
		lo_abs  = (lo_dist < 0) ? ENERGY_W'(-lo_dist) : ENERGY_W'(lo_dist);
		hi_abs  = (hi_dist < 0) ? ENERGY_W'(-hi_dist) : ENERGY_W'(hi_dist);
		peak    = (lo_abs > hi_abs) ? lo_abs : hi_abs;
	end

	// Result stage.
	always_ff @(posedge clk) begin
		peak_s5   <= peak;
		passes_s5 <= (peak <= threshold_q);
	end

	// Valid bits for the input and lane stages and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s5  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done_s5  <= valid_s4;
		end
	end

	assign done        = done_s5;
	assign passes      = passes_s5;
	assign peak_energy = peak_s5;

	// Configuration register writes and reads.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_write && (paddr[ADDR_W-1:2] == REG_THRESHOLD)) begin
			threshold_q <= pwdata[ENERGY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_THRESHOLD) begin
			prdata = DATA_W'(threshold_q);
		end
	end

endmodule
